/* rtl/bilc_pkg.sv */
// ============================================================================
// bilc_pkg
// Shared constants for the bitmap/index-list converter: default bitmap size,
// mode codes, register indexes and reset values, the list terminator and counter limits.
// ============================================================================
`default_nettype none

package bilc_pkg;

    // Default size of the bitmap in bits.
    localparam int unsigned MAP_BITS_DEF = 4096;

    // Item mode codes.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_NEXT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ELEMENT_BYTES = 1'b0;
    localparam logic REG_SCAN_LIMIT    = 1'b1;

    // Register reset values.
    localparam logic [2:0]  ELEMENT_BYTES_RST = 3'd2;
    localparam logic [12:0] SCAN_LIMIT_RST    = 13'd4096;

    // List terminator byte and saturation value of the element counter.
    localparam logic [7:0]  END_BYTE  = 8'hff;
    localparam logic [12:0] COUNT_MAX = 13'h1fff;

endpackage

`default_nettype wire

/* rtl/bitmap_index_list_converter_core.sv */
// ============================================================================
// bitmap_index_list_converter_core
// Converts between a list of big-endian indices and a bitmap held in a
// single-port-style synchronous memory of 32-bit words.
// ============================================================================
// An item is taken when start is high and busy is low, and any result is
// shown on the o_ ports for one cycle with o_valid, in the cycle after the
// last cycle of work on that item; the receiver cannot stall it. A list byte
// that does not complete an element, a terminator, an out-of-range element
// and an unused mode are each handled in ST_IDLE alone. A byte that
// completes an in-range element also passes through ST_SET, as the bitmap
// word is read and then written back. A next-index request is answered from
// ST_IDLE when the cursor is already at the scan limit, else it goes on to
// ST_SCAN, which reads one memory word per cycle until it finds a set bit or
// reaches the limit. A clear request, and reset, sweep the bitmap memory one
// word per cycle; during the sweep busy is high and no item is taken.
// Configuration writes are accepted at any time, but must only be issued
// while the block is idle.
// ============================================================================
`default_nettype none

module bitmap_index_list_converter_core
    import bilc_pkg::*;
#(
    parameter int unsigned MAP_BITS = MAP_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item command port
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_data_byte,
    // result port
    output logic             o_valid,
    output logic [15:0]      o_index_value,
    output logic             o_is_end,
    output logic [12:0]      o_element_count,
    output logic             o_range_error,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned WORDS = (MAP_BITS + 31) / 32;
    localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned CW    = $clog2(MAP_BITS + 1);
    localparam int unsigned XW    = (CW > 16) ? CW : 16;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_SET   = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    // bitmap memory
    logic [31:0]    r_mem [WORDS];
    logic [31:0]    r_rdata;
    logic           w_we;
    logic [WAW-1:0] w_waddr;
    logic [31:0]    w_wdata;
    logic           w_re;
    logic [WAW-1:0] w_raddr;

    // control and pass state
    logic [1:0]     r_state,  n_state;
    logic [CW-1:0]  r_cursor, n_cursor;
    logic [23:0]    r_gather, n_gather;
    logic [1:0]     r_pos,    n_pos;
    logic [12:0]    r_count,  n_count;
    logic           r_ovf,    n_ovf;
    logic [WAW-1:0] r_word,   n_word;
    logic [4:0]     r_lo,     n_lo;
    logic [4:0]     r_bit,    n_bit;
    logic [2:0]     r_eb;
    logic [12:0]    r_limit;

    // result registers
    logic           r_valid,  n_valid;
    logic [15:0]    r_index,  n_index;
    logic           r_end,    n_end;
    logic [12:0]    r_cnt,    n_cnt;
    logic           r_err,    n_err;

    // datapath helpers
    logic           w_accept;
    logic [2:0]     w_nb;
    logic [31:0]    w_gnew;
    logic           w_done;
    logic [12:0]    w_count_inc;
    logic [XW-1:0]  w_lim;
    logic [XW-1:0]  w_cur_x;
    logic [XW-1:0]  w_base;
    logic [XW-1:0]  w_rem;
    logic [31:0]    w_himask;
    logic [31:0]    w_masked;
    logic           w_found;
    logic [4:0]     w_fpos;
    logic [XW-1:0]  w_hit;
    logic           w_cfg_wr;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    // Element width: zero acts as one byte, anything above four as four.
    always_comb begin
        if (r_eb == 3'd0) begin
            w_nb = 3'd1;
        end else if (r_eb > 3'd4) begin
            w_nb = 3'd4;
        end else begin
            w_nb = r_eb;
        end
    end

    assign w_gnew      = {r_gather, i_data_byte};
    assign w_done      = ({1'b0, r_pos} + 3'd1) >= w_nb;
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 13'd1;

    assign w_lim   = (XW'(r_limit) > XW'(MAP_BITS)) ? XW'(MAP_BITS) : XW'(r_limit);
    assign w_cur_x = XW'(r_cursor);

    // Scan window for the word now on the read port: bits from r_lo up to
    // the limit.
    assign w_base   = XW'({r_word, 5'd0});
    assign w_rem    = w_lim - w_base;
    assign w_himask = (w_rem >= XW'(32)) ? 32'hffff_ffff
                                         : ((32'd1 << w_rem[4:0]) - 32'd1);
    assign w_masked = r_rdata & w_himask & (32'hffff_ffff << r_lo);

    // Lowest set bit of the masked word.
    always_comb begin
        w_found = 1'b0;
        w_fpos  = 5'd0;
        for (int b = 31; b >= 0; b--) begin
            if (w_masked[b]) begin
                w_found = 1'b1;
                w_fpos  = 5'(b);
            end
        end
    end

    assign w_hit = w_base | XW'(w_fpos);

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_gather = r_gather;
        n_pos    = r_pos;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_word   = r_word;
        n_lo     = r_lo;
        n_bit    = r_bit;
        n_valid  = 1'b0;
        n_index  = r_index;
        n_end    = r_end;
        n_cnt    = r_cnt;
        n_err    = r_err;
        w_we     = 1'b0;
        w_waddr  = r_word;
        w_wdata  = 32'd0;
        w_re     = 1'b0;
        w_raddr  = r_word;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        MODE_LOAD: begin
                            if (r_pos == 2'd0 && i_data_byte == END_BYTE) begin
                                n_valid  = 1'b1;
                                n_index  = 16'd0;
                                n_end    = 1'b1;
                                n_cnt    = r_count;
                                n_err    = r_ovf;
                                n_gather = 24'd0;
                                n_pos    = 2'd0;
                                n_count  = 13'd0;
                                n_ovf    = 1'b0;
                            end else if (w_done) begin
                                if (w_gnew < 32'(MAP_BITS)) begin
                                    w_re    = 1'b1;
                                    w_raddr = WAW'(w_gnew >> 5);
                                    n_word  = WAW'(w_gnew >> 5);
                                    n_bit   = w_gnew[4:0];
                                    n_state = ST_SET;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                                n_count  = w_count_inc;
                                n_gather = 24'd0;
                                n_pos    = 2'd0;
                            end else begin
                                n_gather = w_gnew[23:0];
                                n_pos    = r_pos + 2'd1;
                            end
                        end
                        MODE_NEXT: begin
                            if (w_cur_x >= w_lim) begin
                                n_valid  = 1'b1;
                                n_index  = 16'd0;
                                n_end    = 1'b1;
                                n_cnt    = r_count;
                                n_err    = 1'b0;
                                n_cursor = '0;
                                n_count  = 13'd0;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = WAW'(w_cur_x >> 5);
                                n_word  = WAW'(w_cur_x >> 5);
                                n_lo    = w_cur_x[4:0];
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            n_cursor = '0;
                            n_gather = 24'd0;
                            n_pos    = 2'd0;
                            n_count  = 13'd0;
                            n_ovf    = 1'b0;
                            n_word   = '0;
                            n_state  = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_word;
                w_wdata = 32'd0;
                if (r_word == WAW'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_word = r_word + WAW'(1);
                end
            end
            ST_SET: begin
                w_we    = 1'b1;
                w_waddr = r_word;
                w_wdata = r_rdata | (32'd1 << r_bit);
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (w_found) begin
                    n_valid  = 1'b1;
                    n_index  = (w_nb == 3'd1) ? {8'd0, w_hit[7:0]} : w_hit[15:0];
                    n_end    = 1'b0;
                    n_cnt    = w_count_inc;
                    n_err    = 1'b0;
                    n_count  = w_count_inc;
                    n_cursor = CW'(w_hit + XW'(1));
                    n_state  = ST_IDLE;
                end else if (w_rem <= XW'(32)) begin
                    // Limit reached inside this word: the pass is over.
                    n_valid  = 1'b1;
                    n_index  = 16'd0;
                    n_end    = 1'b1;
                    n_cnt    = r_count;
                    n_err    = 1'b0;
                    n_cursor = '0;
                    n_count  = 13'd0;
                    n_state  = ST_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_word + WAW'(1);
                    n_word  = r_word + WAW'(1);
                    n_lo    = 5'd0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cursor <= '0;
            r_gather <= 24'd0;
            r_pos    <= 2'd0;
            r_count  <= 13'd0;
            r_ovf    <= 1'b0;
            r_word   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_gather <= n_gather;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_word   <= n_word;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_bit   <= n_bit;
        r_index <= n_index;
        r_end   <= n_end;
        r_cnt   <= n_cnt;
        r_err   <= n_err;
    end

    // Configuration registers.
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eb    <= ELEMENT_BYTES_RST;
            r_limit <= SCAN_LIMIT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_ELEMENT_BYTES: r_eb    <= pwdata[2:0];
                REG_SCAN_LIMIT:    r_limit <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ELEMENT_BYTES: prdata = {29'd0, r_eb};
            REG_SCAN_LIMIT:    prdata = {19'd0, r_limit};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_index_value   = r_index;
    assign o_is_end        = r_end;
    assign o_element_count = r_cnt;
    assign o_range_error   = r_err;

`ifndef NO_ASSERTIONS
    // A bitmap write-back always follows a load item taken in the cycle before.
    a_set_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SET) |-> $past(w_accept && i_mode == MODE_LOAD))
        else $error("bitmap write-back without a completing load item");

    // A found index always carries a nonzero count and no range error.
    a_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_end) |-> (o_element_count != 13'd0 && !o_range_error))
        else $error("found index with bad count or error flag");

    // The cursor never passes the end of the bitmap.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_cursor) <= XW'(MAP_BITS))
        else $error("scan cursor beyond bitmap");

    // A scan only continues to words that still lie below the limit.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (w_base < w_lim))
        else $error("scan word beyond limit");
`endif

endmodule

`default_nettype wire
